[hw/rtl/csd_pkg.sv]
// Shared types and constants for the chemotaxis density stencil.
// Used by csd_front, csd_fifo, csd_back and the top level.
`timescale 1ns / 1ps
package csd_pkg;

    localparam int POS_W  = 10;   // holds a row or depth index up to 1023
    localparam int DATA_W = 32;
    localparam int SIZE_W = 7;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_CHEM_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CHEM_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_CHEM_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_CURV_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_CURV_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_CURV_Z = 3'd5;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 3'd6;
    localparam logic [IDX_W-1:0] REG_SIZE_Z = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] conc;
        logic signed [DATA_W-1:0] dens;
        logic signed [DATA_W-1:0] adv;
        logic signed [DATA_W-1:0] react;
        logic signed [DATA_W-1:0] dfx;
        logic signed [DATA_W-1:0] dfy;
        logic signed [DATA_W-1:0] dfz;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic                     slot;
        logic                     interior;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] chem_x;
        logic signed [DATA_W-1:0] chem_y;
        logic signed [DATA_W-1:0] chem_z;
        logic signed [DATA_W-1:0] curv_x;
        logic signed [DATA_W-1:0] curv_y;
        logic signed [DATA_W-1:0] curv_z;
    } coef_t;

endpackage

[hw/rtl/csd_front.sv]
// Front end: raster position counters and interior classification.
// Depends on csd_pkg; feeds classified requests into csd_fifo.
`timescale 1ns / 1ps
module csd_front #(
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic signed [31:0]         conc_value,
    input  logic signed [31:0]         density_value,
    input  logic signed [31:0]         adv_coef,
    input  logic signed [31:0]         react_coef,
    input  logic signed [31:0]         diff_x,
    input  logic signed [31:0]         diff_y,
    input  logic signed [31:0]         diff_z,
    input  logic                       last_point,
    input  logic [csd_pkg::SIZE_W-1:0] size_y,
    input  logic [csd_pkg::SIZE_W-1:0] size_z,
    output csd_pkg::item_t             item
);
    import csd_pkg::*;

    localparam int JW   = $clog2(MAX_Y);
    localparam int KW   = $clog2(MAX_Z);
    localparam int MAXM = (MAX_Y > MAX_Z) ? MAX_Y : MAX_Z;
    localparam int EW0  = $clog2(MAXM + 2);
    localparam int EW   = (EW0 > SIZE_W) ? EW0 : SIZE_W;

    logic [1:0]    plane_count_reg, plane_count_next;
    logic [JW-1:0] row_pos_reg, row_pos_next;
    logic [KW-1:0] depth_pos_reg, depth_pos_next;
    logic [EW-1:0] sy, sz, j_inc, k_inc;
    logic          interior;

    always_comb
    begin
        if (EW'(size_y) < EW'(3))
            sy = EW'(3);
        else if (EW'(size_y) > EW'(MAX_Y))
            sy = EW'(MAX_Y);
        else
            sy = EW'(size_y);
        if (EW'(size_z) < EW'(3))
            sz = EW'(3);
        else if (EW'(size_z) > EW'(MAX_Z))
            sz = EW'(MAX_Z);
        else
            sz = EW'(size_z);
    end

    assign j_inc = EW'(row_pos_reg) + EW'(1);
    assign k_inc = EW'(depth_pos_reg) + EW'(1);
    assign interior = plane_count_reg[1] && (row_pos_reg != '0) && (j_inc < sy)
                      && (depth_pos_reg != '0) && (k_inc < sz);

    always_comb
    begin
        plane_count_next = plane_count_reg;
        row_pos_next     = row_pos_reg;
        depth_pos_next   = depth_pos_reg;
        if (accept)
        begin
            if (last_point)
            begin
                plane_count_next = '0;
                row_pos_next     = '0;
                depth_pos_next   = '0;
            end
            else if (k_inc >= sz)
            begin
                depth_pos_next = '0;
                if (j_inc >= sy)
                begin
                    row_pos_next     = '0;
                    plane_count_next = (plane_count_reg == 2'd3) ? 2'd2
                                                                 : plane_count_reg + 2'd1;
                end
                else
                    row_pos_next = JW'(j_inc);
            end
            else
                depth_pos_next = KW'(k_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= '0;
            row_pos_reg     <= '0;
            depth_pos_reg   <= '0;
        end
        else
        begin
            plane_count_reg <= plane_count_next;
            row_pos_reg     <= row_pos_next;
            depth_pos_reg   <= depth_pos_next;
        end
    end

    always_comb
    begin
        item.conc     = conc_value;
        item.dens     = density_value;
        item.adv      = adv_coef;
        item.react    = react_coef;
        item.dfx      = diff_x;
        item.dfy      = diff_y;
        item.dfz      = diff_z;
        item.row      = POS_W'(row_pos_reg);
        item.col      = POS_W'(depth_pos_reg);
        item.slot     = plane_count_reg[0];
        item.interior = interior;
    end

endmodule

[hw/rtl/csd_fifo.sv]
// Two-entry request queue between the front end and the back end.
// Depends on csd_pkg for the request type.
`timescale 1ns / 1ps
module csd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  csd_pkg::item_t push_item,
    input  logic           pop,
    output csd_pkg::item_t pop_item,
    output logic           full,
    output logic           empty
);
    import csd_pkg::*;

    item_t      slots_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

[hw/rtl/csd_back.sv]
// Back end: plane store, neighbor reads, and the density update sequencer.
// Depends on csd_pkg; takes requests from csd_fifo, drives the result register.
`timescale 1ns / 1ps
module csd_back #(
    parameter int MAX_Y     = 64,
    parameter int MAX_Z     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  csd_pkg::item_t     q_item,
    output logic               q_pop,
    input  csd_pkg::coef_t     coef,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_density
);
    import csd_pkg::*;

    localparam int PLANE = MAX_Y * MAX_Z;
    localparam int DEPTH = 2 * PLANE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_RD3  = 4'd4;
    localparam logic [3:0] S_DIFF = 4'd5;
    localparam logic [3:0] S_M0   = 4'd6;
    localparam logic [3:0] S_M1   = 4'd7;
    localparam logic [3:0] S_M2   = 4'd8;
    localparam logic [3:0] S_M3   = 4'd9;
    localparam logic [3:0] S_M4   = 4'd10;
    localparam logic [3:0] S_M5   = 4'd11;
    localparam logic [3:0] S_SUM  = 4'd12;
    localparam logic [3:0] S_WR   = 4'd13;

    function automatic logic [AW-1:0] addr_of(input logic slot, input logic [POS_W-1:0] j,
                                              input logic [POS_W-1:0] k);
        return (slot ? AW'(PLANE) : AW'(0)) + AW'(j) * AW'(MAX_Z) + AW'(k);
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (s > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -64'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    logic [3:0]          state_reg, state_next;
    item_t               item_reg;
    logic [63:0]         store [DEPTH];
    logic [63:0]         rd_a_reg, rd_b_reg;
    logic [AW-1:0]       addr_a, addr_b, addr_w;
    logic                wr_en;
    logic                mid;
    logic [POS_W-1:0]    j, k;

    logic signed [31:0]  c0_reg, f0_reg, cim_reg, fim_reg, cjm_reg, fjm_reg;
    logic signed [31:0]  cjp_reg, fjp_reg, ckm_reg, fkm_reg, ckp_reg, fkp_reg;
    logic signed [31:0]  cx_reg, cy_reg, cz_reg, cxx_reg, cyy_reg, czz_reg;
    logic signed [31:0]  ux_reg, uy_reg, uz_reg, uxx_reg, uyy_reg, uzz_reg;
    logic signed [31:0]  lane_a [3];
    logic signed [31:0]  lane_b [3];
    logic signed [63:0]  prod_reg [3];
    logic signed [31:0]  qv [3];
    logic signed [31:0]  qa_reg [3];
    logic signed [31:0]  qe_reg [3];
    logic signed [31:0]  curv_reg, diff_reg, chemo_reg, react_reg;
    logic signed [33:0]  chem3_reg;
    logic signed [34:0]  sum3;
    logic signed [34:0]  total;
    logic                out_valid_reg;
    logic signed [31:0]  new_density_reg;

    assign mid = ~item_reg.slot;
    assign j   = item_reg.row;
    assign k   = item_reg.col;

    always_comb
    begin
        addr_a = addr_of(mid, j, k);
        addr_b = addr_of(item_reg.slot, j, k);
        case (state_reg)
            S_RD1:
            begin
                addr_a = addr_of(mid, j - POS_W'(1), k);
                addr_b = addr_of(mid, j + POS_W'(1), k);
            end
            S_RD2:
            begin
                addr_a = addr_of(mid, j, k - POS_W'(1));
                addr_b = addr_of(mid, j, k + POS_W'(1));
            end
            default: ;
        endcase
    end

    // write after the last neighbor read of the current slot
    assign addr_w = addr_of(item_reg.slot, j, k);
    assign wr_en  = (state_reg == S_RD3) || (state_reg == S_WR);

    always_ff @(posedge clk)
    begin
        rd_a_reg <= store[addr_a];
        rd_b_reg <= store[addr_b];
        if (wr_en)
            store[addr_w] <= {item_reg.conc, item_reg.dens};
    end

    // three multiply lanes shared across the update steps
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            lane_a[l] = '0;
            lane_b[l] = '0;
        end
        case (state_reg)
            S_M0:
            begin
                lane_a[0] = ux_reg; lane_b[0] = cx_reg;
                lane_a[1] = uy_reg; lane_b[1] = cy_reg;
                lane_a[2] = uz_reg; lane_b[2] = cz_reg;
            end
            S_M1:
            begin
                lane_a[0] = coef.curv_x; lane_b[0] = cxx_reg;
                lane_a[1] = coef.curv_y; lane_b[1] = cyy_reg;
                lane_a[2] = coef.curv_z; lane_b[2] = czz_reg;
            end
            S_M2:
            begin
                lane_a[0] = coef.chem_x; lane_b[0] = qa_reg[0];
                lane_a[1] = coef.chem_y; lane_b[1] = qa_reg[1];
                lane_a[2] = coef.chem_z; lane_b[2] = qa_reg[2];
            end
            S_M3:
            begin
                lane_a[0] = f0_reg;         lane_b[0] = curv_reg;
                lane_a[1] = item_reg.adv;   lane_b[1] = uz_reg;
                lane_a[2] = item_reg.react; lane_b[2] = f0_reg;
            end
            S_M4:
            begin
                lane_a[0] = item_reg.dfx; lane_b[0] = uxx_reg;
                lane_a[1] = item_reg.dfy; lane_b[1] = uyy_reg;
                lane_a[2] = item_reg.dfz; lane_b[2] = uzz_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            qv[l] = qround(prod_reg[l]);
        sum3  = 35'(qv[0]) + 35'(qv[1]) + 35'(qv[2]);
        total = 35'(f0_reg) + 35'(chemo_reg) + 35'(qe_reg[1]) + 35'(react_reg)
                + 35'(diff_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
            prod_reg[l] <= 64'(lane_a[l]) * 64'(lane_b[l]);
        if (state_reg == S_IDLE && !q_empty)
            item_reg <= q_item;
        case (state_reg)
            S_RD1:
            begin
                c0_reg  <= rd_a_reg[63:32];
                f0_reg  <= rd_a_reg[31:0];
                cim_reg <= rd_b_reg[63:32];
                fim_reg <= rd_b_reg[31:0];
            end
            S_RD2:
            begin
                cjm_reg <= rd_a_reg[63:32];
                fjm_reg <= rd_a_reg[31:0];
                cjp_reg <= rd_b_reg[63:32];
                fjp_reg <= rd_b_reg[31:0];
            end
            S_RD3:
            begin
                ckm_reg <= rd_a_reg[63:32];
                fkm_reg <= rd_a_reg[31:0];
                ckp_reg <= rd_b_reg[63:32];
                fkp_reg <= rd_b_reg[31:0];
            end
            S_DIFF:
            begin
                cx_reg  <= sat35(35'(item_reg.conc) - 35'(c0_reg));
                cy_reg  <= sat35(35'(cjp_reg) - 35'(c0_reg));
                cz_reg  <= sat35(35'(ckp_reg) - 35'(c0_reg));
                cxx_reg <= sat35(35'(cim_reg) - (35'(c0_reg) <<< 1) + 35'(item_reg.conc));
                cyy_reg <= sat35(35'(cjm_reg) - (35'(c0_reg) <<< 1) + 35'(cjp_reg));
                czz_reg <= sat35(35'(ckm_reg) - (35'(c0_reg) <<< 1) + 35'(ckp_reg));
                ux_reg  <= sat35(35'(item_reg.dens) - 35'(f0_reg));
                uy_reg  <= sat35(35'(fjp_reg) - 35'(f0_reg));
                uz_reg  <= sat35(35'(fkp_reg) - 35'(f0_reg));
                uxx_reg <= sat35(35'(fim_reg) - (35'(f0_reg) <<< 1) + 35'(item_reg.dens));
                uyy_reg <= sat35(35'(fjm_reg) - (35'(f0_reg) <<< 1) + 35'(fjp_reg));
                uzz_reg <= sat35(35'(fkm_reg) - (35'(f0_reg) <<< 1) + 35'(fkp_reg));
            end
            S_M1:
                for (int l = 0; l < 3; l++)
                    qa_reg[l] <= qv[l];
            S_M2:
                curv_reg <= sat35(sum3);
            S_M3:
                chem3_reg <= 34'(qv[0]) + 34'(qv[1]) + 34'(qv[2]);
            S_M4:
                for (int l = 0; l < 3; l++)
                    qe_reg[l] <= qv[l];
            S_M5:
            begin
                diff_reg  <= sat35(sum3);
                chemo_reg <= sat35(35'(chem3_reg) + 35'(qe_reg[0]));
                react_reg <= sat35(-35'(qe_reg[2]));
            end
            default: ;
        endcase
        if (state_reg == S_SUM && (!out_valid_reg || out_ready))
            new_density_reg <= sat35(total);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (!q_empty)
                    state_next = q_item.interior ? S_RD0 : S_WR;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_RD3;
            S_RD3:  state_next = S_DIFF;
            S_DIFF: state_next = S_M0;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_M5;
            S_M5:   state_next = S_SUM;
            S_SUM:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            S_WR:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SUM && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign q_pop       = (state_reg == S_IDLE) && !q_empty;
    assign out_valid   = out_valid_reg;
    assign new_density = new_density_reg;

endmodule

[hw/rtl/chemotaxis_density_stencil_3d.sv]
// Top level of the 3-D chemotaxis density stencil: config registers and wiring.
// Depends on csd_pkg, csd_front, csd_fifo and csd_back.
//
//   port group   direction  handshake            payload
//   input        in         in_valid/in_ready    conc_value .. last_point
//   result       out        out_valid/out_ready  new_density
//   config       in         cfg_we               cfg_index, cfg_data
//
// A boundary point goes through the back end as a dequeue and then a store write.
// An interior point goes through three store reads over two read ports,
// a difference stage, five steps through three shared 32x32 multipliers and
// a final sum. The two-entry queue lets the front accept while the back works.
// Reset (rst_n, async) clears counters, queue and sequencer; the plane store
// is not cleared. A result waiting on out_ready stalls the back end; the front stops once the queue is full.
`timescale 1ns / 1ps
module chemotaxis_density_stencil_3d #(
    parameter int MAX_Y     = 64,
    parameter int MAX_Z     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [31:0]        conc_value,
    input  logic signed [31:0]        density_value,
    input  logic signed [31:0]        adv_coef,
    input  logic signed [31:0]        react_coef,
    input  logic signed [31:0]        diff_x,
    input  logic signed [31:0]        diff_y,
    input  logic signed [31:0]        diff_z,
    input  logic                      last_point,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [31:0]        new_density,
    input  logic                      cfg_we,
    input  logic [csd_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);
    import csd_pkg::*;

    coef_t             coef_reg;
    logic [SIZE_W-1:0] size_y_reg, size_z_reg;
    item_t             front_item, back_item;
    logic              accept, q_full, q_empty, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg   <= '0;
            size_y_reg <= SIZE_W'(64);
            size_z_reg <= SIZE_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHEM_X: coef_reg.chem_x <= cfg_data;
                REG_CHEM_Y: coef_reg.chem_y <= cfg_data;
                REG_CHEM_Z: coef_reg.chem_z <= cfg_data;
                REG_CURV_X: coef_reg.curv_x <= cfg_data;
                REG_CURV_Y: coef_reg.curv_y <= cfg_data;
                REG_CURV_Z: coef_reg.curv_z <= cfg_data;
                REG_SIZE_Y: size_y_reg      <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z: size_z_reg      <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    csd_front #(
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .conc_value    (conc_value),
        .density_value (density_value),
        .adv_coef      (adv_coef),
        .react_coef    (react_coef),
        .diff_x        (diff_x),
        .diff_y        (diff_y),
        .diff_z        (diff_z),
        .last_point    (last_point),
        .size_y        (size_y_reg),
        .size_z        (size_z_reg),
        .item          (front_item)
    );

    csd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (q_pop),
        .pop_item  (back_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    csd_back #(
        .MAX_Y     (MAX_Y),
        .MAX_Z     (MAX_Z),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (back_item),
        .q_pop       (q_pop),
        .coef        (coef_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .new_density (new_density)
    );

endmodule

[tb/density_checker.sv]
// Scoreboard for the chemotaxis density stencil: keeps its own copy of the plane
// stores, counters and registers, predicts each new density and compares.
// Depends on csd_pkg for the register indexes.
`timescale 1ns / 1ps
module density_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] conc_value,
    input  logic signed [31:0] density_value,
    input  logic signed [31:0] adv_coef,
    input  logic signed [31:0] react_coef,
    input  logic signed [31:0] diff_x,
    input  logic signed [31:0] diff_y,
    input  logic signed [31:0] diff_z,
    input  logic               last_point,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] new_density,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 errors,
    output int                 pending
);
    import csd_pkg::*;

    localparam int DEPTH = 64;
    localparam int ROWS  = 64;
    localparam int PLANE = ROWS * DEPTH;

    logic signed [31:0] conc_mem [0:2*PLANE-1];
    logic signed [31:0] dens_mem [0:2*PLANE-1];
    int unsigned        planes, row, col;
    longint             k_chem_x, k_chem_y, k_chem_z, k_curv_x, k_curv_y, k_curv_z;
    logic [6:0]         rows_used, cols_used;
    logic signed [31:0] density_q [$];

    assign pending = density_q.size();

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // rounded fixed-point product, arithmetic shift floors
    function automatic longint fmul(longint a, longint b);
        longint p;
        p = a * b + 64'sd32768;
        return sat(p >>> 16);
    endfunction

    function automatic int unsigned clamp_size(logic [6:0] s);
        if (s < 3)
            return 3;
        if (s > 64)
            return 64;
        return s;
    endfunction

    function automatic int unsigned addr(int unsigned slot, int unsigned j, int unsigned k);
        return (slot & 1) * PLANE + (j % ROWS) * DEPTH + (k % DEPTH);
    endfunction

    task automatic report_mismatch(input logic signed [31:0] got, input logic signed [31:0] want);
        $display("mismatch new_density: got %0d expected %0d at %0t", got, want, $realtime);
        errors++;
    endtask

    task automatic predict_density();
        int unsigned sy, sz, j, k, cur, mid;
        longint c, fn, c0, f0, cim, fim, cjm, fjm, cjp, fjp, ckm, fkm, ckp, fkp;
        longint cx, cy, cz, cxx, cyy, czz, ux, uy, uz, uxx, uyy, uzz;
        longint curv, chemo, advt, react, dif, r;
        sy  = clamp_size(rows_used);
        sz  = clamp_size(cols_used);
        j   = (row >= ROWS) ? 0 : row;
        k   = (col >= DEPTH) ? 0 : col;
        cur = planes & 1;
        mid = cur ^ 1;
        c   = conc_value;
        fn  = density_value;
        if (planes >= 2 && j >= 1 && j + 1 < sy && k >= 1 && k + 1 < sz) begin
            c0  = conc_mem[addr(mid, j, k)];      f0  = dens_mem[addr(mid, j, k)];
            cim = conc_mem[addr(cur, j, k)];      fim = dens_mem[addr(cur, j, k)];
            cjm = conc_mem[addr(mid, j - 1, k)];  fjm = dens_mem[addr(mid, j - 1, k)];
            cjp = conc_mem[addr(mid, j + 1, k)];  fjp = dens_mem[addr(mid, j + 1, k)];
            ckm = conc_mem[addr(mid, j, k - 1)];  fkm = dens_mem[addr(mid, j, k - 1)];
            ckp = conc_mem[addr(mid, j, k + 1)];  fkp = dens_mem[addr(mid, j, k + 1)];
            cx  = sat(c - c0);   cy = sat(cjp - c0);   cz = sat(ckp - c0);
            cxx = sat(cim - 2 * c0 + c);
            cyy = sat(cjm - 2 * c0 + cjp);
            czz = sat(ckm - 2 * c0 + ckp);
            ux  = sat(fn - f0);  uy = sat(fjp - f0);   uz = sat(fkp - f0);
            uxx = sat(fim - 2 * f0 + fn);
            uyy = sat(fjm - 2 * f0 + fjp);
            uzz = sat(fkm - 2 * f0 + fkp);
            curv  = sat(fmul(k_curv_x, cxx) + fmul(k_curv_y, cyy) + fmul(k_curv_z, czz));
            chemo = sat(fmul(k_chem_x, fmul(ux, cx)) + fmul(k_chem_y, fmul(uy, cy))
                        + fmul(k_chem_z, fmul(uz, cz)) + fmul(f0, curv));
            advt  = fmul(adv_coef, uz);
            react = sat(-fmul(react_coef, f0));
            dif   = sat(fmul(diff_x, uxx) + fmul(diff_y, uyy) + fmul(diff_z, uzz));
            r     = sat(f0 + chemo + advt + react + dif);
            density_q.push_back(r[31:0]);
        end
        conc_mem[addr(cur, j, k)] = conc_value;
        dens_mem[addr(cur, j, k)] = density_value;
        if (last_point) begin
            planes = 0;
            row    = 0;
            col    = 0;
        end else if (k + 1 >= sz) begin
            col = 0;
            if (j + 1 >= sy) begin
                row    = 0;
                planes = (planes >= 3) ? 2 : planes + 1;
            end else begin
                row = j + 1;
            end
        end else begin
            col = k + 1;
            row = j;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            planes    = 0;
            row       = 0;
            col       = 0;
            k_chem_x  = 0; k_chem_y = 0; k_chem_z = 0;
            k_curv_x  = 0; k_curv_y = 0; k_curv_z = 0;
            rows_used = 7'd64;
            cols_used = 7'd64;
            density_q.delete();
            errors    = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (density_q.size() == 0) begin
                    $display("unexpected result %0d at %0t", new_density, $realtime);
                    errors++;
                end else begin
                    logic signed [31:0] want;
                    want = density_q.pop_front();
                    if (new_density !== want)
                        report_mismatch(new_density, want);
                end
            end
            if (in_valid && in_ready)
                predict_density();
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHEM_X: k_chem_x = $signed(cfg_data);
                    REG_CHEM_Y: k_chem_y = $signed(cfg_data);
                    REG_CHEM_Z: k_chem_z = $signed(cfg_data);
                    REG_CURV_X: k_curv_x = $signed(cfg_data);
                    REG_CURV_Y: k_curv_y = $signed(cfg_data);
                    REG_CURV_Z: k_curv_z = $signed(cfg_data);
                    REG_SIZE_Y: rows_used = cfg_data[6:0];
                    REG_SIZE_Z: cols_used = cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

[tb/testbench.sv]
// Top of the stencil testbench: clock, reset, grid stimulus, register phases,
// output back-pressure, watchdog and verdict. Depends on csd_pkg,
// chemotaxis_density_stencil_3d and density_checker.
`timescale 1ns / 1ps
module testbench;
    import csd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN       = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] conc_value = '0, density_value = '0, adv_coef = '0, react_coef = '0;
    logic signed [31:0] diff_x = '0, diff_y = '0, diff_z = '0;
    logic               last_point = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] new_density;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    int                 errors, pending;
    int                 idle_cycles = 0;
    int                 points_sent = 0;
    bit                 gaps_on = 1'b1;
    bit                 extreme_data = 1'b0;
    int unsigned        cur_y = 64, cur_z = 64;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    chemotaxis_density_stencil_3d dut (.*);
    density_checker chk (.*);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = gaps_on ? $urandom_range(0, 3) : 0;
            @(negedge clk);
            out_ready = (n == 0);
            repeat (n) @(negedge clk);
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    function automatic logic [31:0] pick_value(bit wide);
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return wide ? $urandom() : 32'h0001_0000;
            default: return wide ? $urandom() : $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic int unsigned eff(int unsigned s);
        return (s < 3) ? 3 : (s > 64) ? 64 : s;
    endfunction

    // coefficients between writes: extremes, full range or mild values
    task automatic configure(input int unsigned sy, input int unsigned sz, input bit wide);
        wait (pending == 0);
        repeat (DRAIN) @(negedge clk);
        write_reg(REG_CHEM_X, pick_value(wide));
        write_reg(REG_CHEM_Y, pick_value(wide));
        write_reg(REG_CHEM_Z, pick_value(wide));
        write_reg(REG_CURV_X, pick_value(wide));
        write_reg(REG_CURV_Y, pick_value(wide));
        write_reg(REG_CURV_Z, pick_value(wide));
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        cur_y = eff(sy & 7'h7F);
        cur_z = eff(sz & 7'h7F);
    endtask

    task automatic send_point(input bit last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        conc_value    = pick_value(extreme_data);
        density_value = pick_value(extreme_data);
        adv_coef      = pick_value(extreme_data);
        react_coef    = pick_value(extreme_data);
        diff_x        = pick_value(extreme_data);
        diff_y        = pick_value(extreme_data);
        diff_z        = pick_value(extreme_data);
        last_point    = last;
        in_valid      = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        points_sent++;
    endtask

    // one grid of nx planes; cut_at >= 0 ends it early with last_point
    task automatic send_grid(input int nx, input int cut_at);
        int n, total;
        total = nx * cur_y * cur_z;
        n = 0;
        for (int i = 0; i < nx; i++)
            for (int j = 0; j < cur_y; j++)
                for (int k = 0; k < cur_z; k++)
                begin
                    if (cut_at < 0 || n <= cut_at)
                        send_point(n == total - 1 || n == cut_at);
                    n++;
                end
        in_valid = 1'b0;
    endtask

    initial
    begin
        int sy, sz;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // smallest grid, extreme data and coefficients
        extreme_data = 1'b1;
        configure(3, 3, 1'b1);
        send_grid(3, -1);
        // clamped sizes, below and above range, then sizes at the range limits
        configure(0, 127, 1'b0);
        send_grid(3, -1);
        configure(2, 1, 1'b1);
        send_grid(3, -1);
        extreme_data = 1'b0;
        configure(64, 3, 1'b0);
        send_grid(3, -1);
        configure(3, 64, 1'b1);
        send_grid(3, -1);

        while (points_sent < 1800)
        begin
            gaps_on      = ($urandom_range(0, 3) != 0);
            extreme_data = ($urandom_range(0, 4) == 0);
            sy = $urandom_range(3, 8);
            sz = $urandom_range(3, 8);
            configure(sy, sz, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                send_grid($urandom_range(1, 4), $urandom_range(0, 3 * sy * sz));
            send_grid($urandom_range(3, 5), -1);
        end

        gaps_on = 1'b0;
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[files.f]
hw/rtl/csd_pkg.sv
hw/rtl/csd_front.sv
hw/rtl/csd_fifo.sv
hw/rtl/csd_back.sv
hw/rtl/chemotaxis_density_stencil_3d.sv
tb/density_checker.sv
tb/testbench.sv
